// ===== hw/rtl/apsv_pkg.sv =====
// apsv_pkg: shared types, constants and the sine table of the additive voice
// used by every module of the voice core; depends on nothing else
package apsv_pkg;

  localparam int MAX_PARTIALS   = 64;
  localparam int PART_BITS      = $clog2(MAX_PARTIALS);
  localparam int MAX_FRAMES     = 1024;
  localparam int FRAME_BITS     = $clog2(MAX_FRAMES);
  localparam int WINDOW_SAMPLES = 64;
  localparam int WIN_BITS       = $clog2(WINDOW_SAMPLES);
  localparam int BLOCK_FRAMES   = 4;
  localparam int BLK_BITS       = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
  localparam int SINE_DEPTH     = 1024;
  localparam int SINE_BITS      = $clog2(SINE_DEPTH);
  localparam int ADDR_BITS      = FRAME_BITS + PART_BITS;
  localparam int PHASE_W        = 24;
  localparam int GAIN_W         = 16;
  localparam int AMP_W          = 16;
  localparam int SINE_W         = 16;
  localparam int SAMPLE_W       = 24;
  localparam int ACC_W          = 56;
  localparam int OUT_DIV        = 64000;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;

  localparam longint unsigned HALF_PI_Q29 = 64'd843314857;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_START   = 3'd1,
    MODE_GAIN    = 3'd2,
    MODE_RELEASE = 3'd3,
    MODE_LOAD    = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC = 3'd0,
    CFG_PARTIALS  = 3'd1,
    CFG_FRAMES    = 3'd2,
    CFG_SUS_START = 3'd3,
    CFG_SUS_END   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [15:0]       gain_value;
    logic [9:0]        load_frame;
    logic [5:0]        load_partial;
    logic [15:0]       load_amplitude;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       voice_active;
  } out_item_t;

  // per-sample settings held steady across the harmonic loop
  typedef struct packed {
    logic                mean;
    logic [WIN_BITS-1:0] s;
    logic [GAIN_W-1:0]   gain;
  } hctl_t;

  typedef logic signed [SINE_W-1:0] sine_lut_t [SINE_DEPTH];

  typedef longint unsigned taylor_t [6];
  localparam taylor_t TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  function automatic logic signed [SINE_W-1:0] quarter_sine(longint unsigned m);
    longint unsigned x, x2, term, pos, neg, sum, r;
    x    = (HALF_PI_Q29 * m) / SINE_DEPTH;
    x2   = (x * x) >> 29;
    term = x;
    pos  = x;
    neg  = 0;
    for (int k = 0; k < 6; k++) begin
      term = (term * x2) >> 29;
      term = term / TAYLOR_DIV[k];
      if ((k % 2) == 0) neg = neg + term;
      else pos = pos + term;
    end
    sum = (pos > neg) ? pos - neg : 64'd0;
    r = (sum * 64'd32767 + (64'd1 << 28)) >> 29;
    if (r > 64'd32767) r = 64'd32767;
    return SINE_W'(r);
  endfunction

  function automatic sine_lut_t build_sine();
    sine_lut_t t;
    longint unsigned d, n;
    d = SINE_DEPTH;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      n = 4 * longint'(i);
      if (n <= d) t[i] = quarter_sine(n);
      else if (n <= 2 * d) t[i] = quarter_sine(2 * d - n);
      else if (n <= 3 * d) t[i] = -quarter_sine(n - 2 * d);
      else t[i] = -quarter_sine(4 * d - n);
    end
    return t;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine();

endpackage

// ===== hw/rtl/apsv_amp_mem.sv =====
// apsv_amp_mem: amplitude frame store, one write port and two registered reads
// depends on apsv_pkg for widths
module apsv_amp_mem (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [apsv_pkg::ADDR_BITS-1:0] wr_addr,
  input  logic [apsv_pkg::AMP_W-1:0]     wr_data,
  input  logic [apsv_pkg::ADDR_BITS-1:0] rd_addr0,
  input  logic [apsv_pkg::ADDR_BITS-1:0] rd_addr1,
  output logic [apsv_pkg::AMP_W-1:0]     rd_data0,
  output logic [apsv_pkg::AMP_W-1:0]     rd_data1
);

  logic [apsv_pkg::AMP_W-1:0] mem [2**apsv_pkg::ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

// ===== hw/rtl/apsv_harm_path.sv =====
// apsv_harm_path: per-harmonic pipeline - sine lookup, amplitude blend,
// gain and sine products and the sample accumulator; depends on apsv_pkg
module apsv_harm_path (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            issue,
  input  logic [apsv_pkg::SINE_BITS-1:0]  sine_idx,
  input  apsv_pkg::hctl_t                 ctl,
  input  logic                            acc_clr,
  input  logic [apsv_pkg::AMP_W-1:0]      a0,
  input  logic [apsv_pkg::AMP_W-1:0]      a1,
  output logic                            busy,
  output logic signed [apsv_pkg::ACC_W-1:0] acc
);

  localparam int PG_W   = apsv_pkg::AMP_W + apsv_pkg::GAIN_W;
  localparam int TERM_W = PG_W + 1 + apsv_pkg::SINE_W;

  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [apsv_pkg::SINE_W-1:0] sine1_r, sine2_r, sine3_r;
  logic [apsv_pkg::AMP_W-1:0]         amp2_r, amp_nxt;
  logic [PG_W-1:0]                    pg3_r;
  logic signed [TERM_W-1:0]           term4_r;
  logic signed [apsv_pkg::ACC_W-1:0]  acc_r;

  logic signed [apsv_pkg::AMP_W:0]                      diff;
  logic signed [apsv_pkg::AMP_W+apsv_pkg::WIN_BITS+1:0] dprod, dq;
  logic [apsv_pkg::AMP_W:0]                             msum;

  always_comb begin
    msum  = {1'b0, a0} + {1'b0, a1};
    diff  = $signed({1'b0, a1}) - $signed({1'b0, a0});
    dprod = diff * $signed({1'b0, ctl.s});
    // divide by the window length, rounding toward zero
    dq = (dprod + (dprod[$high(dprod)] ? (2**apsv_pkg::WIN_BITS) - 1 : 0))
         >>> apsv_pkg::WIN_BITS;
    if (ctl.mean) amp_nxt = msum[apsv_pkg::AMP_W:1];
    else amp_nxt = a0 + dq[apsv_pkg::AMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      acc_r <= '0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (acc_clr) acc_r <= '0;
      else if (v4_r) acc_r <= acc_r + apsv_pkg::ACC_W'(term4_r);
    end
  end

  always_ff @(posedge clk) begin
    sine1_r <= apsv_pkg::SINE_LUT[sine_idx];
    sine2_r <= sine1_r;
    amp2_r  <= amp_nxt;
    sine3_r <= sine2_r;
    pg3_r   <= amp2_r * ctl.gain;
    term4_r <= $signed({1'b0, pg3_r}) * sine3_r;
  end

  assign busy = v1_r | v2_r | v3_r | v4_r;
  assign acc  = acc_r;

endmodule

// ===== hw/rtl/apsv_scale_div.sv =====
// apsv_scale_div: rounds the accumulated sum by the output scale and saturates
// shift by 2^9 then reciprocal multiply by 1/125; depends on apsv_pkg
module apsv_scale_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [apsv_pkg::ACC_W-1:0]   acc,
  output logic                                done,
  output logic signed [apsv_pkg::SAMPLE_W-1:0] res
);

  localparam int QW = apsv_pkg::SAMPLE_W;
  // 64000 is 2^9 times 125
  localparam int POW2_SH = 9;
  localparam int RECIP_SH = 38;
  // ceil(2^38 / 125), exact for a dividend below 2^31
  localparam logic [31:0] RECIP_K = 32'd2199023256;
  localparam logic [apsv_pkg::ACC_W-1:0] DIV_K  = apsv_pkg::ACC_W'(apsv_pkg::OUT_DIV);
  localparam logic [apsv_pkg::ACC_W-1:0] HALF_K = apsv_pkg::ACC_W'(apsv_pkg::OUT_DIV / 2);
  localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_MAX = {1'b1, {(QW-1){1'b0}}};

  logic                       mul_r, done_r, neg_r, sat_r;
  logic [31:0]                m_r;
  logic [apsv_pkg::ACC_W-1:0] mag;
  logic [63:0]                prod;
  logic [QW-1:0]              q_r, lim, qc;

  always_comb begin
    mag  = (acc[apsv_pkg::ACC_W-1] ? apsv_pkg::ACC_W'(-acc) : apsv_pkg::ACC_W'(acc)) + HALF_K;
    prod = m_r * RECIP_K;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= start;
      done_r <= mul_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // below the saturation bound the shifted magnitude fits 31 bits
      m_r   <= mag[POW2_SH +: 32];
      neg_r <= acc[apsv_pkg::ACC_W-1];
      sat_r <= (mag >= (DIV_K << QW));
    end
    if (mul_r) begin
      q_r <= prod[RECIP_SH +: QW];
    end
  end

  always_comb begin
    lim = neg_r ? NEG_MAX : POS_MAX;
    qc  = (sat_r || (q_r > lim)) ? lim : q_r;
    res = neg_r ? -$signed(qc) : $signed(qc);
  end

  assign done = done_r;

endmodule

// ===== hw/rtl/additive_partial_synth_voice_core.sv =====
// additive_partial_synth_voice_core: top level, voice state, control sequencer
// uses apsv_pkg, apsv_amp_mem, apsv_harm_path and apsv_scale_div
//
// One additive voice. A sample tick passes through the accept cycle, the setup state,
// one cycle per harmonic (partial_count, up to 64), the pipeline drain, the output
// scaling and the hand-over; the pace is set by the single harmonic pipeline fed from
// the dual-read amplitude store. A tick on a silent voice goes from the accept cycle
// straight to the hand-over, a tick on which the frames run out through setup to the
// hand-over. Other items (start, set gain, release, load amplitude) are done in the
// accept cycle. A finished sample waits in the output register while the next item is
// taken; the hand-over cycle stalls while that register is still full.
// Configuration writes are taken in any cycle; cfg_ready is always high.
module additive_partial_synth_voice_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  apsv_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output apsv_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [apsv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apsv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int FB = apsv_pkg::FRAME_BITS;
  localparam int PB = apsv_pkg::PART_BITS;
  localparam int WB = apsv_pkg::WIN_BITS;
  localparam int BB = apsv_pkg::BLK_BITS;
  localparam int GW = apsv_pkg::GAIN_W;
  localparam int NB = BB + WB;

  // configuration
  logic [apsv_pkg::PHASE_W-1:0] phase_inc_r;
  logic [PB:0]                  partials_r;
  logic [FB:0]                  frames_r;
  logic [FB-1:0]                sus_start_r, sus_end_r;

  // voice state
  apsv_pkg::state_t state_r, state_nxt;
  logic [FB-1:0]    frame_idx_r, frame_idx_nxt, win_frame_r, win_frame_nxt;
  logic             voice_r, voice_nxt, win_mean_r, win_mean_nxt;
  logic [apsv_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [GW-1:0]    cur_gain_r, cur_gain_nxt, tgt_gain_r, tgt_gain_nxt;
  logic signed [GW:0] step_r, step_nxt;
  logic [WB-1:0]    winpos_r, winpos_nxt;
  logic [BB-1:0]    blk_r, blk_nxt;

  // per-sample loop
  apsv_pkg::hctl_t  hctl_r, hctl_nxt;
  logic [apsv_pkg::PHASE_W-1:0] base_r, base_nxt, ph_r, ph_nxt;
  logic [PB-1:0]    k_r, k_nxt;
  logic [PB:0]      pc_r, pc_nxt;
  logic             zero_r, zero_nxt;

  logic             out_valid_r, out_valid_nxt;
  apsv_pkg::out_item_t out_item_r, out_item_nxt;

  // datapath hookup
  logic             issue, acc_clr, div_start, div_done, busy;
  logic             mem_we;
  logic [apsv_pkg::ADDR_BITS-1:0] rd_addr0, rd_addr1;
  logic [apsv_pkg::AMP_W-1:0]     a0, a1;
  logic signed [apsv_pkg::ACC_W-1:0]    acc;
  logic signed [apsv_pkg::SAMPLE_W-1:0] div_res;

  logic [FB:0]      fc;
  logic [PB:0]      pc;
  logic [NB-1:0]    n;
  logic signed [GW+NB+1:0] gprod, gq;
  logic [GW+1:0]    gsum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      partials_r  <= (PB+1)'(1);
      frames_r    <= (FB+1)'(2);
      sus_start_r <= '0;
      sus_end_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        apsv_pkg::CFG_PHASE_INC: phase_inc_r <= cfg_data[apsv_pkg::PHASE_W-1:0];
        apsv_pkg::CFG_PARTIALS:  partials_r  <= cfg_data[PB:0];
        apsv_pkg::CFG_FRAMES:    frames_r    <= cfg_data[FB:0];
        apsv_pkg::CFG_SUS_START: sus_start_r <= cfg_data[FB-1:0];
        apsv_pkg::CFG_SUS_END:   sus_end_r   <= cfg_data[FB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apsv_pkg::ST_IDLE;
      frame_idx_r <= '0;
      win_frame_r <= '0;
      voice_r     <= 1'b0;
      win_mean_r  <= 1'b0;
      phase_r     <= '0;
      cur_gain_r  <= '0;
      tgt_gain_r  <= '0;
      step_r      <= '0;
      winpos_r    <= '0;
      blk_r       <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      zero_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_idx_r <= frame_idx_nxt;
      win_frame_r <= win_frame_nxt;
      voice_r     <= voice_nxt;
      win_mean_r  <= win_mean_nxt;
      phase_r     <= phase_nxt;
      cur_gain_r  <= cur_gain_nxt;
      tgt_gain_r  <= tgt_gain_nxt;
      step_r      <= step_nxt;
      winpos_r    <= winpos_nxt;
      blk_r       <= blk_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      zero_r      <= zero_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hctl_r     <= hctl_nxt;
    base_r     <= base_nxt;
    ph_r       <= ph_nxt;
    pc_r       <= pc_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    frame_idx_nxt = frame_idx_r;
    win_frame_nxt = win_frame_r;
    voice_nxt     = voice_r;
    win_mean_nxt  = win_mean_r;
    phase_nxt     = phase_r;
    cur_gain_nxt  = cur_gain_r;
    tgt_gain_nxt  = tgt_gain_r;
    step_nxt      = step_r;
    winpos_nxt    = winpos_r;
    blk_nxt       = blk_r;
    hctl_nxt      = hctl_r;
    base_nxt      = base_r;
    ph_nxt        = ph_r;
    k_nxt         = k_r;
    pc_nxt        = pc_r;
    zero_nxt      = zero_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    issue         = 1'b0;
    acc_clr       = 1'b0;
    div_start     = 1'b0;
    mem_we        = 1'b0;

    fc = (frames_r > (FB+1)'(apsv_pkg::MAX_FRAMES)) ? (FB+1)'(apsv_pkg::MAX_FRAMES) : frames_r;
    pc = (partials_r > (PB+1)'(apsv_pkg::MAX_PARTIALS)) ?
         (PB+1)'(apsv_pkg::MAX_PARTIALS) : partials_r;
    n     = {blk_r, winpos_r};
    gprod = '0;
    gq    = '0;
    gsum  = '0;

    if (win_mean_r) begin
      rd_addr0 = {sus_start_r, k_r};
      rd_addr1 = {sus_end_r, k_r};
    end else begin
      rd_addr0 = {win_frame_r, k_r};
      rd_addr1 = {win_frame_r + 1'b1, k_r};
    end

    case (state_r)
      apsv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_item.mode)
            apsv_pkg::MODE_TICK: begin
              if (voice_r) begin
                state_nxt = apsv_pkg::ST_SETUP;
              end else begin
                zero_nxt  = 1'b1;
                state_nxt = apsv_pkg::ST_FIN;
              end
            end
            apsv_pkg::MODE_START: begin
              cur_gain_nxt  = in_item.gain_value;
              tgt_gain_nxt  = in_item.gain_value;
              step_nxt      = '0;
              frame_idx_nxt = '0;
              winpos_nxt    = '0;
              blk_nxt       = '0;
              voice_nxt     = 1'b1;
            end
            apsv_pkg::MODE_GAIN: tgt_gain_nxt = in_item.gain_value;
            apsv_pkg::MODE_RELEASE: begin
              if (voice_r) frame_idx_nxt = sus_end_r;
            end
            apsv_pkg::MODE_LOAD: mem_we = 1'b1;
            default: ;
          endcase
        end
      end

      apsv_pkg::ST_SETUP: begin
        if (winpos_r == '0) begin
          if (blk_r == '0) step_nxt = $signed({1'b0, tgt_gain_r}) - $signed({1'b0, cur_gain_r});
          if (frame_idx_r >= sus_start_r && frame_idx_r < sus_end_r) begin
            win_mean_nxt = 1'b1;
          end else if ({1'b0, frame_idx_r} + 1'b1 >= fc) begin
            // frames ran out: the voice stops on this tick
            voice_nxt = 1'b0;
          end else begin
            win_mean_nxt  = 1'b0;
            win_frame_nxt = frame_idx_r;
            frame_idx_nxt = frame_idx_r + 1'b1;
          end
        end
        if (!voice_nxt) begin
          winpos_nxt = '0;
          blk_nxt    = '0;
          zero_nxt   = 1'b1;
          state_nxt  = apsv_pkg::ST_FIN;
        end else begin
          // gain ramp across the block, rounding toward zero
          gprod = step_nxt * $signed({1'b0, n});
          gq    = (gprod + (gprod[$high(gprod)] ? (2**NB) - 1 : 0)) >>> NB;
          gsum  = (GW+2)'({1'b0, cur_gain_r}) + (GW+2)'(gq);
          hctl_nxt.mean = win_mean_nxt;
          hctl_nxt.s    = winpos_r;
          hctl_nxt.gain = gsum[GW-1:0];
          base_nxt   = phase_r;
          ph_nxt     = phase_r;
          k_nxt      = '0;
          pc_nxt     = pc;
          zero_nxt   = 1'b0;
          acc_clr    = 1'b1;
          phase_nxt  = phase_r + phase_inc_r;
          winpos_nxt = winpos_r + 1'b1;
          if (winpos_r == WB'(apsv_pkg::WINDOW_SAMPLES - 1)) begin
            winpos_nxt = '0;
            blk_nxt    = blk_r + 1'b1;
            if (blk_r == BB'(apsv_pkg::BLOCK_FRAMES - 1)) begin
              blk_nxt      = '0;
              cur_gain_nxt = cur_gain_r + step_nxt[GW-1:0];
              step_nxt     = '0;
            end
          end
          // no harmonics: the cleared sum goes straight to scaling
          if (pc == '0) state_nxt = apsv_pkg::ST_DRAIN;
          else state_nxt = apsv_pkg::ST_RUN;
        end
      end

      apsv_pkg::ST_RUN: begin
        issue  = 1'b1;
        ph_nxt = ph_r + base_r;
        k_nxt  = k_r + 1'b1;
        if ({1'b0, k_r} == pc_r - 1'b1) state_nxt = apsv_pkg::ST_DRAIN;
      end

      apsv_pkg::ST_DRAIN: begin
        if (!busy) begin
          div_start = 1'b1;
          state_nxt = apsv_pkg::ST_DIV;
        end
      end

      apsv_pkg::ST_DIV: begin
        if (div_done) state_nxt = apsv_pkg::ST_FIN;
      end

      apsv_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (zero_r) begin
            out_item_nxt.sample       = '0;
            out_item_nxt.voice_active = 1'b0;
          end else begin
            out_item_nxt.sample       = div_res;
            out_item_nxt.voice_active = 1'b1;
          end
          state_nxt = apsv_pkg::ST_IDLE;
        end
      end

      default: state_nxt = apsv_pkg::ST_IDLE;
    endcase
  end

  apsv_amp_mem u_mem (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  ({in_item.load_frame, in_item.load_partial}),
    .wr_data  (in_item.load_amplitude),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (a0),
    .rd_data1 (a1)
  );

  apsv_harm_path u_harm (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (issue),
    .sine_idx (ph_r[apsv_pkg::PHASE_W-1 -: apsv_pkg::SINE_BITS]),
    .ctl      (hctl_r),
    .acc_clr  (acc_clr),
    .a0       (a0),
    .a1       (a1),
    .busy     (busy),
    .acc      (acc)
  );

  apsv_scale_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .acc   (acc),
    .done  (div_done),
    .res   (div_res)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
